>>> hw/rtl/esc_frm_pkg.sv
// ----------------------------------------------------------------------------
// Escaped command framer package
// Frame marker bytes, field widths and defaults shared by the framer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package esc_frm_pkg;

  // Frame marker bytes.
  localparam logic [7:0] MARK_START = 8'hA0;
  localparam logic [7:0] MARK_END   = 8'hA5;
  localparam logic [7:0] MARK_ESC   = 8'hA6;
  localparam logic [7:0] FLIP_MASK  = 8'h80;

  // Lowest byte value that must be escaped; the highest is MARK_ESC.
  localparam logic [7:0] ESC_LOW = 8'hA0;

  // Default mailbox size in bytes.
  localparam int FRAME_BYTES_DEF = 32;

  // Field widths.
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 4;
  localparam int WORD_W   = 32;
  localparam int OFS_OUT_W = 3;

  // Stream bus widths (fields packed from bit 0, padded to whole bytes).
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 40;

endpackage

>>> hw/rtl/escaped_command_framer.sv
// ----------------------------------------------------------------------------
// Escaped command framer
// Output: a word that an input byte completes is on the master side in the cycle
//   after the byte's transaction; a second closing word waits in the spare slot.
// Throughput: one input byte per cycle while the master side takes words; a
//   two-word closing byte holds the slave side off until its spare word moves.
// Reset: synchronous rst clears the frame state and empties both output slots.
//
// Wraps command bytes into a mailbox frame (START, length, escaped payload,
// END) and packs the framed bytes little-endian into 32-bit words, each with
// its word offset. The final word of a frame carries the doorbell flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module escaped_command_framer #(
  parameter int FRAME_BYTES = esc_frm_pkg::FRAME_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Slave side: command bytes.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // s_tdata fields from bit 0: cmd_byte[7:0], cmd_length[11:8], zero pad.
  input  logic [esc_frm_pkg::S_DATA_W-1:0] s_tdata,
  input  logic                             s_tlast,   // is_last_byte
  // Master side: mailbox words.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // m_tdata fields from bit 0: mailbox_word[31:0], word_offset[34:32], zero pad.
  output logic [esc_frm_pkg::M_DATA_W-1:0] m_tdata,
  output logic                             m_tlast    // ring_doorbell
);

  // Number of words in one mailbox; the offset counter wraps at this value.
  localparam int WORDS = FRAME_BYTES / 4;
  localparam int OFS_W = (WORDS > 2) ? $clog2(WORDS) : 1;
  // Width used to bring the offset counter to the 3-bit output field.
  localparam int OFS_X_W = (OFS_W > esc_frm_pkg::OFS_OUT_W) ? OFS_W : esc_frm_pkg::OFS_OUT_W;

  // Frame state. Pending holds up to three framed bytes not yet sent, with
  // zeros above the valid count.
  logic [23:0]      pending;
  logic [1:0]       pending_cnt;
  logic [OFS_W-1:0] word_cnt;
  logic             inside_frame;

  // Output slot and a spare slot for the second word of a closing byte.
  logic                        out_valid;
  logic [31:0]                 out_word;
  logic [esc_frm_pkg::OFS_OUT_W-1:0] out_ofs;
  logic                        out_bell;
  logic                        spare_valid;
  logic [31:0]                 spare_word;
  logic [esc_frm_pkg::OFS_OUT_W-1:0] spare_ofs;

  // Per-transaction framing logic.
  logic        accept;
  logic        pop;
  logic [7:0]  cmd_byte;
  logic [3:0]  cmd_length;
  logic        esc_hit;
  logic        has_payload;
  logic        closing;
  logic [1:0]  hdr_n;
  logic [1:0]  pay_n;
  logic [15:0] pay_v;
  logic [39:0] tail;
  logic [63:0] fbuf;
  logic [3:0]  n_bytes;
  logic        emit0;
  logic        emit1;
  logic        bell0;
  logic [OFS_W-1:0]   ofs_inc0;
  logic [OFS_X_W-1:0] ofs_x0;
  logic [OFS_X_W-1:0] ofs_x1;

  logic [23:0]      pending_next;
  logic [1:0]       pending_cnt_next;
  logic [OFS_W-1:0] word_cnt_next;
  logic             inside_frame_next;

  assign cmd_byte   = s_tdata[7:0];
  assign cmd_length = s_tdata[11:8];

  // The slave side waits only while a spare word is queued, or the output
  // slot is full and not being taken.
  assign s_tready = !spare_valid && (!out_valid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign pop      = out_valid && m_tready;

  assign m_tvalid = out_valid;
  assign m_tlast  = out_bell;
  assign m_tdata  = {5'b0, out_ofs, out_word};

  // Offsets of the first and second word this transaction may produce.
  assign ofs_inc0 = (word_cnt == OFS_W'(WORDS - 1)) ? '0 : word_cnt + 1'b1;
  assign ofs_x0   = OFS_X_W'(word_cnt);
  assign ofs_x1   = OFS_X_W'(ofs_inc0);

  always_comb begin
    // Bytes in the ESC range are escaped as ESC followed by byte XOR 0x80.
    esc_hit     = (cmd_byte >= esc_frm_pkg::ESC_LOW) && (cmd_byte <= esc_frm_pkg::MARK_ESC);
    // A first byte with length zero opens and closes an empty frame.
    has_payload = inside_frame || (cmd_length != 4'd0);
    closing     = s_tlast || !has_payload;
    hdr_n       = inside_frame ? 2'd0 : 2'd2;

    if (!has_payload) begin
      pay_n = 2'd0;
      pay_v = 16'h0;
    end else if (esc_hit) begin
      pay_n = 2'd2;
      pay_v = {cmd_byte ^ esc_frm_pkg::FLIP_MASK, esc_frm_pkg::MARK_ESC};
    end else begin
      pay_n = 2'd1;
      pay_v = {8'h0, cmd_byte};
    end

    // New framed bytes of this transaction, in order, from byte 0 up.
    tail = inside_frame ? 40'h0 : 40'({4'h0, cmd_length, esc_frm_pkg::MARK_START});
    tail = tail | (40'(pay_v) << {hdr_n, 3'b000});
    if (closing) begin
      tail = tail | (40'(esc_frm_pkg::MARK_END) << {3'(hdr_n) + 3'(pay_n), 3'b000});
    end

    // Pending bytes come first, then the new ones.
    fbuf    = 64'(pending) | (64'(tail) << {pending_cnt, 3'b000});
    n_bytes = 4'(pending_cnt) + 4'(hdr_n) + 4'(pay_n) + 4'(closing);

    // A closing transaction flushes everything, up to two words; otherwise
    // only a completed word leaves.
    emit0 = closing || (n_bytes >= 4'd4);
    emit1 = closing && (n_bytes > 4'd4);
    bell0 = closing && (n_bytes <= 4'd4);

    if (closing) begin
      pending_next      = 24'h0;
      pending_cnt_next  = 2'd0;
      word_cnt_next     = '0;
      inside_frame_next = 1'b0;
    end else if (n_bytes >= 4'd4) begin
      pending_next      = fbuf[55:32];
      pending_cnt_next  = 2'(n_bytes - 4'd4);
      word_cnt_next     = ofs_inc0;
      inside_frame_next = 1'b1;
    end else begin
      pending_next      = fbuf[23:0];
      pending_cnt_next  = 2'(n_bytes);
      word_cnt_next     = word_cnt;
      inside_frame_next = 1'b1;
    end
  end

  // Frame state, updated on each accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending      <= 24'h0;
      pending_cnt  <= 2'd0;
      word_cnt     <= '0;
      inside_frame <= 1'b0;
    end else if (accept) begin
      pending      <= pending_next;
      pending_cnt  <= pending_cnt_next;
      word_cnt     <= word_cnt_next;
      inside_frame <= inside_frame_next;
    end
  end

  // Result registers. The spare slot always holds a doorbell word, so it
  // carries no flag of its own.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (spare_valid && pop) begin
      out_valid   <= 1'b1;
      spare_valid <= 1'b0;
    end else if (accept && emit0) begin
      out_valid   <= 1'b1;
      spare_valid <= emit1;
    end else if (pop) begin
      out_valid   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (spare_valid && pop) begin
      out_word <= spare_word;
      out_ofs  <= spare_ofs;
      out_bell <= 1'b1;
    end else if (accept && emit0) begin
      out_word <= fbuf[31:0];
      out_ofs  <= ofs_x0[esc_frm_pkg::OFS_OUT_W-1:0];
      out_bell <= bell0;
    end
    if (accept && emit1) begin
      spare_word <= fbuf[63:32];
      spare_ofs  <= ofs_x1[esc_frm_pkg::OFS_OUT_W-1:0];
    end
  end

  // A spare word only exists behind a full output slot.
  a_spare_behind_out: assert property (@(posedge clk) disable iff (rst)
    spare_valid |-> out_valid)
    else $error("spare word queued with empty output slot");

  // The word ahead of a spare word is never the frame's last.
  a_spare_first_no_bell: assert property (@(posedge clk) disable iff (rst)
    spare_valid |-> !out_bell)
    else $error("doorbell on a word that has a successor");

  // A closing byte leaves the block between frames.
  a_close_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> !inside_frame)
    else $error("frame still open after closing byte");

  // An empty command is a single doorbell word.
  a_empty_one_word: assert property (@(posedge clk) disable iff (rst)
    (accept && !inside_frame && cmd_length == 4'd0) |=>
      (out_valid && out_bell && !spare_valid))
    else $error("empty command did not give a single doorbell word");

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// Escaped command framer testbench
// Sends command bytes into the framer and checks every mailbox word, its word
// offset and its doorbell flag against typed words for directed rows that give
// them, else against a cycle-free model of the framing and packing rules. A
// short table of directed bytes comes first, then random frames with random
// burst gaps on the byte side and random stalls on the word side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int RAND_ITEMS   = 525;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [esc_frm_pkg::WORD_W-1:0]    word;
    logic [esc_frm_pkg::OFS_OUT_W-1:0] ofs;
    logic                              bell;
  } frame_word_t;

  // A row with n_typed of zero is checked against the model below.
  typedef struct packed {
    logic [esc_frm_pkg::BYTE_W-1:0] cmd_byte;
    logic [esc_frm_pkg::LEN_W-1:0]  cmd_len;
    logic                           last;
    logic [1:0]                     n_typed;
    frame_word_t                    exp_a;
    frame_word_t                    exp_b;
  } dir_row_t;

  localparam frame_word_t NO_WORD = '0;

  dir_row_t dir_rows [0:22] = '{
    // Empty commands: START, zero length and END in one word.
    '{8'h55, 4'd0,  1'b0, 2'd1, '{32'h00A5_00A0, 3'd0, 1'b1}, NO_WORD},
    '{8'hFF, 4'd0,  1'b1, 2'd1, '{32'h00A5_00A0, 3'd0, 1'b1}, NO_WORD},
    // One-byte commands; an escaped byte spills END into a second word.
    '{8'h00, 4'd1,  1'b1, 2'd1, '{32'hA500_01A0, 3'd0, 1'b1}, NO_WORD},
    '{8'hA0, 4'd1,  1'b1, 2'd2, '{32'h20A6_01A0, 3'd0, 1'b0},
                                '{32'h0000_00A5, 3'd1, 1'b1}},
    '{8'hFF, 4'd15, 1'b1, 2'd1, '{32'hA5FF_0FA0, 3'd0, 1'b1}, NO_WORD},
    '{8'hA6, 4'd14, 1'b1, 2'd2, '{32'h26A6_0EA0, 3'd0, 1'b0},
                                '{32'h0000_00A5, 3'd1, 1'b1}},
    // Overlong frame whose length byte disagrees with its payload; the
    // word offset wraps past the end of the mailbox.
    '{8'hA0, 4'd15, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'hA1, 4'd0,  1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'hA2, 4'd7,  1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'hA3, 4'd15, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'hA4, 4'd0,  1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'hA5, 4'd9,  1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'hA6, 4'd3,  1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'h00, 4'd0,  1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'hFF, 4'd15, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'h9F, 4'd1,  1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'hA7, 4'd2,  1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'hA6, 4'd4,  1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'hA5, 4'd8,  1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'hA4, 4'd0,  1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'hA3, 4'd11, 1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'hA2, 4'd5,  1'b0, 2'd0, NO_WORD, NO_WORD},
    '{8'hA0, 4'd15, 1'b1, 2'd0, NO_WORD, NO_WORD}
  };

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [esc_frm_pkg::S_DATA_W-1:0] s_tdata = '0;
  logic                             s_tlast = 1'b0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [esc_frm_pkg::M_DATA_W-1:0] m_tdata;
  logic                             m_tlast;

  // Framing state of the model.
  logic [23:0]                       held_bytes = '0;
  logic [1:0]                        held_cnt = '0;
  logic [esc_frm_pkg::OFS_OUT_W-1:0] next_ofs = '0;
  logic                              frame_open = 1'b0;

  frame_word_t expected_words [$];
  frame_word_t step_words [$];
  int          mismatch_cnt = 0;
  int          idle_cycles = 0;
  int          bytes_taken = 0;
  int          burst_left = 0;

  escaped_command_framer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Frames one command byte and leaves the words it completes in step_words.
  function automatic void frame_command_byte(input logic [7:0] b, input logic [3:0] len,
                                             input logic last);
    logic [7:0]  fb [0:11];
    int          n;
    int          pos;
    int          i;
    logic        closing;
    logic        payload;
    frame_word_t fw;
    n = 0;
    pos = 0;
    closing = last;
    payload = 1'b1;
    step_words.delete();
    for (i = 0; i < held_cnt; i++) begin
      fb[n] = held_bytes[8*i +: 8];
      n = n + 1;
    end
    if (!frame_open) begin
      fb[n] = esc_frm_pkg::MARK_START;
      fb[n+1] = {4'b0, len};
      n = n + 2;
      frame_open = 1'b1;
      if (len == 0) begin
        payload = 1'b0;
        closing = 1'b1;
      end
    end
    if (payload) begin
      if (b >= esc_frm_pkg::ESC_LOW && b <= esc_frm_pkg::MARK_ESC) begin
        fb[n] = esc_frm_pkg::MARK_ESC;
        fb[n+1] = b ^ esc_frm_pkg::FLIP_MASK;
        n = n + 2;
      end else begin
        fb[n] = b;
        n = n + 1;
      end
    end
    if (closing) begin
      fb[n] = esc_frm_pkg::MARK_END;
      n = n + 1;
    end
    while (n - pos >= 4) begin
      fw.word = {fb[pos+3], fb[pos+2], fb[pos+1], fb[pos]};
      pos = pos + 4;
      fw.ofs = next_ofs;
      fw.bell = closing && (pos == n);
      step_words.push_back(fw);
      // Eight words per 32-byte mailbox: the 3-bit offset wraps on its own.
      next_ofs = next_ofs + 1'b1;
    end
    if (closing) begin
      if (pos < n) begin
        fw.word = '0;
        for (i = 0; pos + i < n; i++) fw.word[8*i +: 8] = fb[pos+i];
        fw.ofs = next_ofs;
        fw.bell = 1'b1;
        step_words.push_back(fw);
      end
      held_bytes = '0;
      held_cnt = '0;
      next_ofs = '0;
      frame_open = 1'b0;
    end else begin
      held_bytes = '0;
      held_cnt = 2'(n - pos);
      for (i = 0; i < held_cnt; i++) held_bytes[8*i +: 8] = fb[pos+i];
    end
  endfunction

  function automatic logic [7:0] pick_cmd_byte();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return esc_frm_pkg::ESC_LOW + 8'($urandom_range(0, 6));
    if (sel == 4) return 8'h00;
    if (sel == 5) return 8'hFF;
    if (sel == 6) return ($urandom_range(0, 1) != 0) ? 8'h9F : 8'hA7;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic log_mismatch(input string what, input frame_word_t got,
                              input frame_word_t exp);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("ERROR %0t: %s: got word %h ofs %0d bell %b, expected word %h ofs %0d bell %b",
               $realtime, what, got.word, got.ofs, got.bell, exp.word, exp.ofs, exp.bell);
  endtask

  // Offers one command byte, waits for its transaction and queues the words
  // it should produce: the typed ones when given, else the model's.
  task automatic send_cmd_byte(input logic [7:0] b, input logic [3:0] len, input logic last,
                               input logic [1:0] n_typed, input frame_word_t exp_a,
                               input frame_word_t exp_b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tdata <= {{(esc_frm_pkg::S_DATA_W-esc_frm_pkg::BYTE_W-esc_frm_pkg::LEN_W){1'b0}},
                len, b};
    s_tlast <= last;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_taken++;
    frame_command_byte(b, len, last);
    if (n_typed == 0) begin
      foreach (step_words[i]) expected_words.push_back(step_words[i]);
    end else begin
      expected_words.push_back(exp_a);
      if (n_typed > 1) expected_words.push_back(exp_b);
    end
  endtask

  // Stops offering bytes until every queued word has come out.
  task automatic wait_words_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  // Word-side checker and idle counter.
  always @(posedge clk) begin
    frame_word_t got;
    frame_word_t exp;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (m_tvalid && m_tready) begin
        got.word = m_tdata[esc_frm_pkg::WORD_W-1:0];
        got.ofs = m_tdata[esc_frm_pkg::WORD_W +: esc_frm_pkg::OFS_OUT_W];
        got.bell = m_tlast;
        if (expected_words.size() == 0) begin
          log_mismatch("unexpected mailbox word", got, NO_WORD);
        end else begin
          exp = expected_words.pop_front();
          if (got.word !== exp.word || got.ofs !== exp.ofs || got.bell !== exp.bell)
            log_mismatch("mailbox word differs", got, exp);
        end
      end
    end
  end

  // Word-side stalls: changing patterns, plus one long hold-off that lets the
  // framer fill up and push back on the byte side.
  initial begin : word_sink
    int  mode;
    int  span;
    int  tick;
    bit  held;
    held = 1'b0;
    tick = 0;
    while (rst) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      repeat (span) begin
        @(posedge clk);
        tick++;
        if (!held && bytes_taken >= HOLD_AT) begin
          held = 1'b1;
          m_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= (tick % 5 != 0);
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int          rand_sent;
    int          sel;
    int          n;
    logic [3:0]  len;
    bit          paused;
    rand_sent = 0;
    paused = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[r])
      send_cmd_byte(dir_rows[r].cmd_byte, dir_rows[r].cmd_len, dir_rows[r].last,
                    dir_rows[r].n_typed, dir_rows[r].exp_a, dir_rows[r].exp_b);
    wait_words_drained();

    while (rand_sent < RAND_ITEMS) begin
      if (!paused && rand_sent >= RAND_ITEMS / 2) begin
        paused = 1'b1;
        wait_words_drained();
      end
      sel = $urandom_range(0, 19);
      if (sel < 2) begin
        send_cmd_byte(pick_cmd_byte(), 4'd0, 1'($urandom_range(0, 1)), 2'd0,
                      NO_WORD, NO_WORD);
        rand_sent++;
      end else begin
        len = 4'($urandom_range(1, 15));
        // Mostly well-formed commands; some disagree with their length byte
        // or run long enough to wrap the word offset.
        n = (sel < 5) ? $urandom_range(1, 40) : len;
        for (int i = 0; i < n; i++) begin
          send_cmd_byte(pick_cmd_byte(), (i == 0) ? len : 4'($urandom_range(0, 15)),
                        (i == n - 1), 2'd0, NO_WORD, NO_WORD);
          rand_sent++;
        end
      end
    end

    wait_words_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && expected_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
